### rtl/core/spq_pkg.sv
package spq_pkg;

    // Store depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 5;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_ERASE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Input transaction payload
    typedef struct packed {
        logic                    opcode;
        logic signed [VAL_W-1:0] value;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic signed [VAL_W-1:0] highest;
        logic                    is_empty;
        logic [OCC_W-1:0]        occupancy;
        logic [1:0]              status;
    } t_out;

    // Operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ers;
    } t_ctrl;

    // What a cell shows its neighbors
    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    valid;
        logic                    le;
    } t_link;

endpackage

### rtl/core/spq_cell.sv
module spq_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spq_pkg::t_ctrl               i_ctrl,
    input  logic signed [spq_pkg::VAL_W-1:0] i_value,
    input  spq_pkg::t_link               i_left,
    input  spq_pkg::t_link               i_right,
    output spq_pkg::t_link               o_link,
    output logic                         o_eq,
    output logic signed [spq_pkg::VAL_W-1:0] o_next_val,
    output logic                         o_next_valid
);
    import spq_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    r_valid;
    logic                    n_valid;
    logic                    w_le;
    logic                    w_ge;

    // Compare the stored entry against the broadcast value
    assign w_le = r_valid && (r_val <= i_value);
    assign w_ge = r_valid && (r_val >= i_value);
    assign o_eq = r_valid && (r_val == i_value);

    // Keep, take the new value, or shift from a neighbor
    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (!w_le) begin
                if (i_left.le) begin
                    n_val   = i_value;
                    n_valid = 1'b1;
                end else begin
                    n_val   = i_left.val;
                    n_valid = i_left.valid;
                end
            end
        end else if (i_ctrl.ers) begin
            if (w_ge) begin
                n_val   = i_right.val;
                n_valid = i_right.valid;
            end
        end
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_link       = '{val: r_val, valid: r_valid, le: w_le};
    assign o_next_val   = n_val;
    assign o_next_valid = n_valid;

endmodule

### rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue: keeps up to CAPACITY signed 32-bit values in ascending order in a
// row of cells, each holding one entry. An insert places the value after any equal entries;
// an erase removes one entry equal to the value. Every transaction produces one result with
// the largest stored value (-1 when empty), an empty flag, the entry count and a status
// (done, insert dropped because full, erase value not found). All cells compare against the
// broadcast value at once and shift by one place, so one transaction is accepted per clock
// while the output register is free or being drained; the result appears in the output register
// in the cycle after acceptance. No clearing pass is needed after reset.
module sorted_priority_queue_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  spq_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spq_pkg::t_out  o_out_data
);
    import spq_pkg::*;

    t_link                   w_link [CAPACITY];
    logic signed [VAL_W-1:0] w_next_val [CAPACITY];
    logic [CAPACITY-1:0]     w_next_valid;
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_valid;
    t_ctrl                   w_ctrl;
    logic                    w_acc;
    logic                    w_full;
    logic                    w_found;
    logic [1:0]              w_status;
    logic signed [VAL_W-1:0] w_high;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    t_out                    r_out;

    // Accept while the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_full  = w_valid[CAPACITY-1];
    assign w_found = |w_eq;

    // Decide the operation for the cells
    always_comb begin
        w_ctrl   = '{ins: 1'b0, ers: 1'b0};
        w_status = ST_DONE;
        if (i_in_data.opcode == OP_INSERT) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_ctrl.ins = w_acc;
            end
        end else begin
            if (!w_found) begin
                w_status = ST_NOT_FOUND;
            end else begin
                w_ctrl.ers = w_acc;
            end
        end
    end

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link w_left;
        t_link w_right;
        if (g == 0) begin : g_first
            assign w_left = '{val: '0, valid: 1'b1, le: 1'b1};
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '{val: '0, valid: 1'b0, le: 1'b0};
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_in_data.value),
            .i_left       (w_left),
            .i_right      (w_right),
            .o_link       (w_link[g]),
            .o_eq         (w_eq[g]),
            .o_next_val   (w_next_val[g]),
            .o_next_valid (w_next_valid[g])
        );
        assign w_valid[g] = w_link[g].valid;
    end

    // Pick the last valid entry of the updated row
    always_comb begin
        w_high = '1;
        for (int i = 0; i < CAPACITY - 1; i++) begin
            if (w_next_valid[i] && !w_next_valid[i+1]) begin
                w_high = w_next_val[i];
            end
        end
        if (w_next_valid[CAPACITY-1]) begin
            w_high = w_next_val[CAPACITY-1];
        end
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.ers) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out.highest   <= w_high;
            r_out.is_empty  <= (n_count == '0);
            r_out.occupancy <= OCC_W'(n_count);
            r_out.status    <= w_status;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Count matches the occupied cells
    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("entry count differs from occupied cells");

    // Count never exceeds the row
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A successful insert grows the count by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow count");

    // Empty result reports minus one
    a_empty_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_empty) |-> o_out_data.highest == -32'sd1)
        else $error("empty result with wrong highest");

endmodule

### bench/sorted_priority_queue_top_tb.sv
module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1126;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_in   in_data   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_data;

    // Shadow copy of the sorted store, updated on each accepted transaction
    logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
    int                      shadow_count = 0;

    t_out pending_results[$];
    t_out oldest_result;
    int   error_count = 0;
    int   cycle_count = 0;
    bit   tx_idle_on  = 1'b1;

    sorted_priority_queue_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Apply one operation to the shadow store and return the result it must produce
    function automatic t_out predict_queue_result(input t_in item);
        t_out       res;
        int         pos;
        int         idx;
        logic [1:0] st;
        st  = ST_DONE;
        pos = 0;
        if (item.opcode == OP_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                st = ST_FULL;
            end else begin
                // equal entries stay ahead of the new one
                while (pos < shadow_count &&
                       $signed(shadow_entries[pos]) <= $signed(item.value))
                    pos++;
                for (idx = shadow_count; idx > pos; idx--)
                    shadow_entries[idx] = shadow_entries[idx - 1];
                shadow_entries[pos] = item.value;
                shadow_count++;
            end
        end else begin
            while (pos < shadow_count && shadow_entries[pos] != item.value)
                pos++;
            if (pos >= shadow_count) begin
                st = ST_NOT_FOUND;
            end else begin
                for (idx = pos; idx + 1 < shadow_count; idx++)
                    shadow_entries[idx] = shadow_entries[idx + 1];
                shadow_count--;
            end
        end
        // empty store reports all ones
        res.highest   = (shadow_count > 0) ? shadow_entries[shadow_count - 1] : '1;
        res.is_empty  = (shadow_count == 0);
        res.occupancy = shadow_count[OCC_W-1:0];
        res.status    = st;
        return res;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Favor values already stored so erases hit and inserts make duplicates
    function automatic logic signed [VAL_W-1:0] pick_value();
        int                      r;
        logic signed [VAL_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_count > 0) begin
            v = shadow_entries[$urandom_range(0, shadow_count - 1)];
        end else if (r < 70) begin
            v = $urandom_range(0, 16);
            v = v - 8;
        end else if (r < 90) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 5))
                0:       v = VAL_MAX;
                1:       v = VAL_MIN;
                2:       v = VAL_MAX - 1;
                3:       v = VAL_MIN + 1;
                4:       v = '1;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // Drive one transaction, hold it until accepted, then record its result
    task automatic send_item(input logic op, input logic signed [VAL_W-1:0] val);
        t_in item;
        int  gap;
        item.opcode = op;
        item.value  = val;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_queue_result(item));
    endtask

    task automatic test_erase_on_empty();
        send_item(OP_ERASE, '0);
    endtask

    task automatic test_extreme_values();
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, '0);
        send_item(OP_ERASE, 32'sd5);
        // duplicate goes in, one copy comes out
        send_item(OP_INSERT, '0);
        send_item(OP_ERASE, '0);
    endtask

    task automatic test_fill_past_capacity();
        logic signed [VAL_W-1:0] v;
        while (shadow_count < CAPACITY) begin
            v = $urandom_range(0, 200);
            send_item(OP_INSERT, v - 100);
        end
        // full store drops this one
        send_item(OP_INSERT, VAL_MAX);
    endtask

    task automatic test_erase_extremes();
        send_item(OP_ERASE, VAL_MAX);
        send_item(OP_ERASE, VAL_MIN);
        send_item(OP_ERASE, $urandom);
    endtask

    // Segments that lean toward filling, draining or neither
    task automatic test_random_traffic(input int num_items);
        int sent;
        int seg_len;
        int insert_pct;
        int j;
        sent = 0;
        while (sent < num_items) begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            tx_idle_on = ($urandom_range(0, 3) != 0);
            for (j = 0; j < seg_len && sent < num_items; j++) begin
                send_item(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_ERASE,
                          pick_value());
                sent++;
            end
        end
        tx_idle_on = 1'b1;
    endtask

    // Main sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_erase_on_empty();
        test_extreme_values();
        test_fill_past_capacity();
        test_erase_extremes();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stall the output side: short and long stalls, with long ready stretches
    initial begin : out_ready_driver
        int run;
        int r;
        bit level;
        run   = 0;
        level = 1'b0;
        forever begin
            @(posedge clk);
            if (run == 0) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    level = 1'b1;
                    run   = $urandom_range(50, 200);
                end else if (r < 70) begin
                    level = 1'b1;
                    run   = $urandom_range(1, 12);
                end else if (r < 95) begin
                    level = 1'b0;
                    run   = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    run   = $urandom_range(10, 40);
                end
            end
            out_ready <= level;
            run--;
        end
    end

    function automatic void compare_result_field(input string name,
                                                 input logic [31:0] want,
                                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check each accepted result against the oldest pending one
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual %p",
                         $time, out_data);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                compare_result_field("highest", 32'(oldest_result.highest),
                                     32'(out_data.highest));
                compare_result_field("is_empty", 32'(oldest_result.is_empty),
                                     32'(out_data.is_empty));
                compare_result_field("occupancy", 32'(oldest_result.occupancy),
                                     32'(out_data.occupancy));
                compare_result_field("status", 32'(oldest_result.status),
                                     32'(out_data.status));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
